// ===== hw/rtl/sgsa_pkg.sv =====
// ----------------------------------------------------------------------------
// sgsa_pkg
// Shared types, constants and the saturating add for the spline gradient
// scatter-add block.
// ----------------------------------------------------------------------------
package sgsa_pkg;

    localparam int GRAD_W     = 32;
    localparam int SUM_W      = 48;
    localparam int IDX_W      = 7;
    localparam int POS_W      = 6;
    localparam int CFG_W      = 7;
    localparam int MIN_POINTS = 2;

    // interval index that means "before the first point"
    localparam logic [IDX_W-1:0] IDX_BEFORE_FIRST = '1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // one input transfer
    typedef struct packed {
        logic signed [IDX_W-1:0]  interval_index;
        logic signed [GRAD_W-1:0] grad_value;
        logic signed [GRAD_W-1:0] grad_slope;
        logic signed [GRAD_W-1:0] grad_curve;
        logic signed [GRAD_W-1:0] grad_cubic;
        logic signed [GRAD_W-1:0] grad_knot;
        logic                     row_end;
    } t_in_item;

    // one result transfer
    typedef struct packed {
        logic [POS_W-1:0]        point_position;
        logic signed [SUM_W-1:0] sum_knot;
        logic signed [SUM_W-1:0] sum_value;
        logic signed [SUM_W-1:0] sum_slope;
        logic signed [SUM_W-1:0] sum_curve;
        logic signed [SUM_W-1:0] sum_cubic;
        logic                    bad_index_seen;
        logic                    final_point;
    } t_out_item;

    // one store entry: the five sums of a point
    typedef struct packed {
        logic signed [SUM_W-1:0] knot;
        logic signed [SUM_W-1:0] value;
        logic signed [SUM_W-1:0] slope;
        logic signed [SUM_W-1:0] curve;
        logic signed [SUM_W-1:0] cubic;
    } t_sums;

    localparam int SUMS_W = $bits(t_sums);

    // accumulate with clamping at the 48-bit signed limits
    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]  acc,
        input logic signed [GRAD_W-1:0] grad
    );
        logic signed [SUM_W:0] s;
        s = $signed({acc[SUM_W-1], acc}) +
            $signed({{(SUM_W+1-GRAD_W){grad[GRAD_W-1]}}, grad});
        if (s[SUM_W] != s[SUM_W-1]) begin
            sat_add = s[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sat_add = s[SUM_W-1:0];
        end
    endfunction

endpackage

// ===== hw/rtl/sgsa_ram.sv =====
// ----------------------------------------------------------------------------
// sgsa_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read (read-before-write on the same address).
// ----------------------------------------------------------------------------
module sgsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sgsa_store.sv =====
// ----------------------------------------------------------------------------
// sgsa_store
// Sum store: RAM of per-point sums, valid bit per entry so that a single
// clear wipes the whole store, and write-to-read forwarding for same-entry
// accesses on the same edge.
// ----------------------------------------------------------------------------
module sgsa_store #(
    parameter int MAX_POINTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_rd_en,
    input  logic [$clog2(MAX_POINTS)-1:0] i_rd_addr,
    input  logic                          i_wr_en,
    input  logic [$clog2(MAX_POINTS)-1:0] i_wr_addr,
    input  sgsa_pkg::t_sums               i_wr_data,
    output sgsa_pkg::t_sums               o_rd_data
);

    logic [MAX_POINTS-1:0]  r_valid;
    logic                   r_rd_vld;
    logic                   r_fwd_hit;
    sgsa_pkg::t_sums        r_fwd_data;
    logic [sgsa_pkg::SUMS_W-1:0] w_ram_rdata;

    sgsa_ram #(
        .WIDTH (sgsa_pkg::SUMS_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr_en),
        .i_waddr (i_wr_addr),
        .i_wdata (i_wr_data),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (w_ram_rdata)
    );

    // entry valid bits: clear wipes all, a write marks its entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_clear) begin
                r_valid <= '0;
            end
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    // read side tracking, held along with the RAM output between reads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_vld  <= r_valid[i_rd_addr];
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= i_wr_data;
        end
    end

    // forwarded data wins, an entry not written since clear or reset reads as zero
    always_comb begin
        if (r_fwd_hit) begin
            o_rd_data = r_fwd_data;
        end else if (r_rd_vld) begin
            o_rd_data = sgsa_pkg::t_sums'(w_ram_rdata);
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

// ===== hw/rtl/spline_gradient_scatter_add.sv =====
// ----------------------------------------------------------------------------
// spline_gradient_scatter_add
// Scatter-add of spline gradients into per-point sums with a drain on row end.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) takes one gradient
//   item per transfer. Each item with a legal index is a read-modify-write
//   of one store entry: read at the transfer edge, saturating add and write
//   in the following cycle. Back-to-back items to the same point are
//   forwarded, so one item per cycle is sustained outside a drain; an item's
//   add is done in the cycle after its transfer. An item with row_end set
//   raises o_in_stall for the drain: the store is read one point per cycle
//   and each point's sums leave on the output channel (o_out_valid /
//   i_out_stall / o_out_item), point 0 first, the last one marked
//   final_point. The store and the bad index flag clear as the final point
//   enters the output register, and input transfers resume.
//   A stalled output holds its item; the drain pauses behind it.
//   i_cfg_we / i_cfg_wdata set the point count; write it only while idle.
//   Reset (synchronous, active low) clears all sums and the flag and sets
//   the point count to MAX_POINTS.
// ----------------------------------------------------------------------------
module spline_gradient_scatter_add #(
    parameter int MAX_POINTS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sgsa_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  sgsa_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output sgsa_pkg::t_out_item            o_out_item
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_EDGE,
        MODE_FULL
    } t_mode;

    typedef enum logic {
        ST_ACCEPT,
        ST_DRAIN
    } t_state;

    // configuration
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // input decode
    logic                        w_in_xfer;
    logic [sgsa_pkg::IDX_W-1:0]  w_idx;
    logic [sgsa_pkg::IDX_W-1:0]  w_last_idx;
    t_mode                       w_mode;
    logic [AW-1:0]               w_addr;

    // update stage
    logic                r_s1_valid;
    t_mode               r_s1_mode;
    logic [AW-1:0]       r_s1_addr;
    sgsa_pkg::t_in_item  r_s1_item;
    sgsa_pkg::t_sums     w_cur;
    sgsa_pkg::t_sums     w_upd;
    logic                w_wr_en;

    // drain sequencer
    t_state              r_state;
    logic [CW-1:0]       r_ptr;
    logic                r_d1_valid;
    logic [AW-1:0]       r_d1_pos;
    logic                r_d1_fin;
    logic                r_bad;
    logic                r_o_valid;
    sgsa_pkg::t_out_item r_o_item;
    logic                w_d1_move;
    logic                w_issue;
    logic                w_clear;
    logic                w_rd_en;
    logic [AW-1:0]       w_rd_addr;

    // point count, clamped to its legal range on write
    always_comb begin
        if (i_cfg_wdata < sgsa_pkg::CFG_W'(sgsa_pkg::MIN_POINTS)) begin
            n_count = CW'(sgsa_pkg::MIN_POINTS);
        end else if (i_cfg_wdata > sgsa_pkg::CFG_W'(MAX_POINTS)) begin
            n_count = CW'(MAX_POINTS);
        end else begin
            n_count = CW'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CW'(MAX_POINTS);
        end else if (i_cfg_we) begin
            r_count <= n_count;
        end
    end

    // index decode: before first point, last point, interior, or bad
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_idx      = i_in_item.interval_index;
    assign w_last_idx = sgsa_pkg::IDX_W'(r_count) - sgsa_pkg::IDX_W'(1);

    always_comb begin
        w_mode = MODE_NONE;
        w_addr = w_idx[AW-1:0];
        if (w_idx == sgsa_pkg::IDX_BEFORE_FIRST) begin
            w_mode = MODE_EDGE;
            w_addr = '0;
        end else if (!w_idx[sgsa_pkg::IDX_W-1] && (w_idx == w_last_idx)) begin
            w_mode = MODE_EDGE;
        end else if (!w_idx[sgsa_pkg::IDX_W-1] && (w_idx < w_last_idx)) begin
            w_mode = MODE_FULL;
        end
    end

    // update stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_in_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_mode <= w_mode;
            r_s1_addr <= w_addr;
            r_s1_item <= i_in_item;
        end
    end

    // saturating accumulate on the entry read at transfer
    always_comb begin
        w_upd = w_cur;
        unique case (r_s1_mode)
            MODE_EDGE: begin
                w_upd.value = sgsa_pkg::sat_add(w_cur.value, r_s1_item.grad_value);
                w_upd.knot  = sgsa_pkg::sat_add(w_cur.knot,  r_s1_item.grad_knot);
            end
            MODE_FULL: begin
                w_upd.value = sgsa_pkg::sat_add(w_cur.value, r_s1_item.grad_value);
                w_upd.slope = sgsa_pkg::sat_add(w_cur.slope, r_s1_item.grad_slope);
                w_upd.curve = sgsa_pkg::sat_add(w_cur.curve, r_s1_item.grad_curve);
                w_upd.cubic = sgsa_pkg::sat_add(w_cur.cubic, r_s1_item.grad_cubic);
                w_upd.knot  = sgsa_pkg::sat_add(w_cur.knot,  r_s1_item.grad_knot);
            end
            default: begin
                w_upd = w_cur;
            end
        endcase
    end

    assign w_wr_en = r_s1_valid && (r_s1_mode != MODE_NONE);

    // drain control
    assign w_d1_move = r_d1_valid && (!r_o_valid || !i_out_stall);
    assign w_issue   = (r_state == ST_DRAIN) && (r_ptr != r_count) &&
                       (!r_d1_valid || w_d1_move);
    assign w_clear   = w_d1_move && r_d1_fin;

    // store read port shared by input items and the drain
    assign w_rd_en   = w_in_xfer || w_issue;
    assign w_rd_addr = (r_state == ST_DRAIN) ? r_ptr[AW-1:0] : w_addr;

    sgsa_store #(
        .MAX_POINTS (MAX_POINTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_clear),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (w_upd),
        .o_rd_data (w_cur)
    );

    // sequencer state, bad flag, read stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_ACCEPT;
            r_ptr      <= '0;
            r_d1_valid <= 1'b0;
            r_bad      <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_ACCEPT: begin
                    if (w_in_xfer && i_in_item.row_end) begin
                        r_state <= ST_DRAIN;
                        r_ptr   <= '0;
                    end
                end
                ST_DRAIN: begin
                    if (w_clear) begin
                        r_state <= ST_ACCEPT;
                        r_ptr   <= '0;
                    end else if (w_issue) begin
                        r_ptr <= r_ptr + CW'(1);
                    end
                end
                default: begin
                    r_state <= ST_ACCEPT;
                end
            endcase

            if (w_clear) begin
                r_bad <= 1'b0;
            end else if (w_in_xfer && (w_mode == MODE_NONE)) begin
                r_bad <= 1'b1;
            end

            if (w_issue) begin
                r_d1_valid <= 1'b1;
                r_d1_pos   <= r_ptr[AW-1:0];
                r_d1_fin   <= (r_ptr == (r_count - CW'(1)));
            end else if (w_d1_move) begin
                r_d1_valid <= 1'b0;
            end

            if (w_d1_move) begin
                r_o_valid                 <= 1'b1;
                r_o_item.point_position   <= sgsa_pkg::POS_W'(r_d1_pos);
                r_o_item.sum_knot         <= w_cur.knot;
                r_o_item.sum_value        <= w_cur.value;
                r_o_item.sum_slope        <= r_d1_fin ? '0 : w_cur.slope;
                r_o_item.sum_curve        <= r_d1_fin ? '0 : w_cur.curve;
                r_o_item.sum_cubic        <= r_d1_fin ? '0 : w_cur.cubic;
                r_o_item.bad_index_seen   <= r_bad;
                r_o_item.final_point      <= r_d1_fin;
            end else if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state == ST_DRAIN);
    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_o_item;

endmodule

// ===== dv/spline_gradient_scatter_add_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spline_gradient_scatter_add_checker
// Watches the input, result and configuration ports of the scatter-add block.
// It keeps its own copy of the per-point sums and the point count. Each
// accepted row end queues the drain it should cause, and each result transfer
// is compared field by field against the oldest queued point.
// ----------------------------------------------------------------------------
module spline_gradient_scatter_add_checker
    import sgsa_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  t_in_item         i_in_item,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  t_out_item        i_out_item,
    output int               o_mismatch_count,
    output int               o_results_due
);

    // shadow store and point count
    logic signed [SUM_W-1:0] knot_acc  [MAX_POINTS];
    logic signed [SUM_W-1:0] value_acc [MAX_POINTS];
    logic signed [SUM_W-1:0] slope_acc [MAX_POINTS];
    logic signed [SUM_W-1:0] curve_acc [MAX_POINTS];
    logic signed [SUM_W-1:0] cubic_acc [MAX_POINTS];
    logic                    bad_seen;
    logic [CFG_W-1:0]        count_reg;

    // drain results still to arrive, oldest first
    t_out_item pending_points[$];
    t_out_item want;

    // count register clamped to the legal range
    function automatic int points_in_use();
        int n;
        n = int'(count_reg);
        if (n < MIN_POINTS) begin
            n = MIN_POINTS;
        end
        if (n > MAX_POINTS) begin
            n = MAX_POINTS;
        end
        return n;
    endfunction

    // widen to 64 bits, add, clamp to the 48-bit limits
    function automatic logic signed [SUM_W-1:0] clamp_add(
        input logic signed [SUM_W-1:0]  acc,
        input logic signed [GRAD_W-1:0] grad
    );
        longint total;
        total = longint'(acc) + longint'(grad);
        if (total > longint'(SUM_MAX)) begin
            total = longint'(SUM_MAX);
        end
        if (total < longint'(SUM_MIN)) begin
            total = longint'(SUM_MIN);
        end
        return total[SUM_W-1:0];
    endfunction

    task automatic clear_sums();
        for (int k = 0; k < MAX_POINTS; k++) begin
            knot_acc[k]  = '0;
            value_acc[k] = '0;
            slope_acc[k] = '0;
            curve_acc[k] = '0;
            cubic_acc[k] = '0;
        end
        bad_seen = 1'b0;
    endtask

    // scatter one item into the store; a row end queues the whole drain
    task automatic accumulate(input t_in_item it);
        int        n;
        int        idx;
        t_out_item r;
        n   = points_in_use();
        idx = int'(it.interval_index);
        if (idx == -1) begin
            value_acc[0] = clamp_add(value_acc[0], it.grad_value);
            knot_acc[0]  = clamp_add(knot_acc[0], it.grad_knot);
        end else if (idx == n - 1) begin
            value_acc[idx] = clamp_add(value_acc[idx], it.grad_value);
            knot_acc[idx]  = clamp_add(knot_acc[idx], it.grad_knot);
        end else if (idx >= 0 && idx < n - 1) begin
            value_acc[idx] = clamp_add(value_acc[idx], it.grad_value);
            slope_acc[idx] = clamp_add(slope_acc[idx], it.grad_slope);
            curve_acc[idx] = clamp_add(curve_acc[idx], it.grad_curve);
            cubic_acc[idx] = clamp_add(cubic_acc[idx], it.grad_cubic);
            knot_acc[idx]  = clamp_add(knot_acc[idx], it.grad_knot);
        end else begin
            bad_seen = 1'b1;
        end

        if (it.row_end) begin
            for (int k = 0; k < n; k++) begin
                r.point_position = POS_W'(k);
                r.sum_knot       = knot_acc[k];
                r.sum_value      = value_acc[k];
                // last point carries no b, c, d terms
                r.sum_slope      = (k == n - 1) ? '0 : slope_acc[k];
                r.sum_curve      = (k == n - 1) ? '0 : curve_acc[k];
                r.sum_cubic      = (k == n - 1) ? '0 : cubic_acc[k];
                r.bad_index_seen = bad_seen;
                r.final_point    = (k == n - 1);
                pending_points.push_back(r);
            end
            clear_sums();
        end
    endtask

    task automatic check_field(
        input string            field,
        input int               pos,
        input logic [SUM_W-1:0] exp_val,
        input logic [SUM_W-1:0] act_val
    );
        if (act_val !== exp_val) begin
            $display("%0t: %s of point %0d: expected %h, got %h",
                     $time, field, pos, exp_val, act_val);
            o_mismatch_count++;
        end
    endtask

    // sample every port at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_sums();
            count_reg = CFG_W'(MAX_POINTS);
            pending_points.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_points.size() == 0) begin
                    $display("%0t: result transfer with none expected: %h",
                             $time, i_out_item);
                    o_mismatch_count++;
                end else begin
                    want = pending_points.pop_front();
                    check_field("point_position", want.point_position,
                                want.point_position, i_out_item.point_position);
                    check_field("sum_knot", want.point_position,
                                want.sum_knot, i_out_item.sum_knot);
                    check_field("sum_value", want.point_position,
                                want.sum_value, i_out_item.sum_value);
                    check_field("sum_slope", want.point_position,
                                want.sum_slope, i_out_item.sum_slope);
                    check_field("sum_curve", want.point_position,
                                want.sum_curve, i_out_item.sum_curve);
                    check_field("sum_cubic", want.point_position,
                                want.sum_cubic, i_out_item.sum_cubic);
                    check_field("bad_index_seen", want.point_position,
                                want.bad_index_seen, i_out_item.bad_index_seen);
                    check_field("final_point", want.point_position,
                                want.final_point, i_out_item.final_point);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                accumulate(i_in_item);
            end
            // written only while idle, so no item sees the new count this edge
            if (i_cfg_we) begin
                count_reg = i_cfg_wdata;
            end
        end
        o_results_due = pending_points.size();
    end

endmodule

// ===== dv/spline_gradient_scatter_add_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spline_gradient_scatter_add_tb
// Drives gradient rows into the scatter-add block and gives the verdict.
// A directed part covers the index edge cases, count clamping, a count
// change inside a row and same-sign extremes piled onto two points; random
// rows follow under four idle and stall patterns. All checking is done by
// the checker module.
// ----------------------------------------------------------------------------
module spline_gradient_scatter_add_tb;
    import sgsa_pkg::*;

    localparam int MAX_POINTS    = 64;
    localparam int CLK_HALF      = 4;
    localparam int SETTLE        = 10;
    localparam int PHASE_ITEMS   = 110;
    // a few same-sign extreme pairs on two neighboring points
    localparam int EXTREME_PAIRS = 8;
    // a full 64-point drain after every item under heavy stall stays within this limit
    localparam int RUN_LIMIT     = 500000;

    localparam logic signed [GRAD_W-1:0] GRAD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [GRAD_W-1:0] GRAD_MIN = 32'sh8000_0000;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             cfg_we      = 1'b0;
    logic [CFG_W-1:0] cfg_wdata   = '0;
    logic             in_valid    = 1'b0;
    logic             in_stall;
    t_in_item         in_item     = '0;
    logic             out_valid;
    logic             out_stall   = 1'b0;
    t_out_item        out_item;

    int     mismatches;
    int     results_due;
    int     in_idle_pct   = 0;
    int     out_stall_pct = 0;
    longint cycle_count   = 0;

    spline_gradient_scatter_add #(
        .MAX_POINTS (MAX_POINTS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    spline_gradient_scatter_add_checker #(
        .MAX_POINTS (MAX_POINTS)
    ) checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_in_item        (in_item),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_item       (out_item),
        .o_mismatch_count (mismatches),
        .o_results_due    (results_due)
    );

    // clock
    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("%0t: run limit of %0d cycles reached", $time, RUN_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side stall
    always @(negedge i_clk) begin
        out_stall = ($urandom_range(99) < out_stall_pct);
    end

    function automatic t_in_item make_item(
        input int                       idx,
        input logic signed [GRAD_W-1:0] gv,
        input logic signed [GRAD_W-1:0] gs,
        input logic signed [GRAD_W-1:0] gc,
        input logic signed [GRAD_W-1:0] gd,
        input logic signed [GRAD_W-1:0] gk,
        input logic                     last
    );
        t_in_item it;
        it.interval_index = idx[IDX_W-1:0];
        it.grad_value     = gv;
        it.grad_slope     = gs;
        it.grad_curve     = gc;
        it.grad_cubic     = gd;
        it.grad_knot      = gk;
        it.row_end        = last;
        return it;
    endfunction

    // mostly full-range values, with small ones and both extremes mixed in
    function automatic logic signed [GRAD_W-1:0] rand_grad();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            return $urandom;
        end else if (pick < 80) begin
            return $signed($urandom_range(2000)) - 1000;
        end else if (pick < 90) begin
            return GRAD_MAX;
        end
        return GRAD_MIN;
    endfunction

    // called right after a falling edge; returns right after one
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_item  = it;
        do begin
            @(posedge i_clk);
        end while (in_stall);
        @(negedge i_clk);
    endtask

    // drop valid, wait for every queued point, then let the last add finish
    task automatic wait_idle();
        in_valid = 1'b0;
        while (results_due != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge i_clk);
        cfg_we    = 1'b0;
        @(negedge i_clk);
    endtask

    // random rows under one idle pattern and one count setting
    task automatic run_phase(input int in_pct, input int out_pct,
                             input logic [CFG_W-1:0] count);
        int n;
        int left_in_row;
        int pick;
        int idx;
        n = int'(count);
        if (n < MIN_POINTS) begin
            n = MIN_POINTS;
        end
        if (n > MAX_POINTS) begin
            n = MAX_POINTS;
        end
        write_count(count);
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        left_in_row   = 0;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (left_in_row == 0) begin
                left_in_row = ($urandom_range(9) == 0) ? $urandom_range(40, 13)
                                                       : $urandom_range(12, 1);
            end
            pick = $urandom_range(99);
            if (pick < 10) begin
                idx = -1;
            end else if (pick < 22) begin
                idx = n - 1;
            end else if (pick < 30) begin
                // out of range, on either side
                if (n < MAX_POINTS && $urandom_range(1)) begin
                    idx = $urandom_range(MAX_POINTS - 1, n);
                end else begin
                    idx = -int'($urandom_range(64, 2));
                end
            end else begin
                idx = $urandom_range(n - 2, 0);
            end
            send_item(make_item(idx, rand_grad(), rand_grad(), rand_grad(),
                                rand_grad(), rand_grad(),
                                (left_in_row == 1) || (i == PHASE_ITEMS - 1)));
            left_in_row--;
        end
        wait_idle();
    endtask

    initial begin
        // hold reset, then release it on a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset count: both ends, extremes, two bad negative indices
        send_item(make_item(-1, GRAD_MAX, GRAD_MAX, GRAD_MAX, GRAD_MAX, GRAD_MAX, 1'b0));
        send_item(make_item(63, GRAD_MIN, GRAD_MIN, GRAD_MIN, GRAD_MIN, GRAD_MIN, 1'b0));
        send_item(make_item(0, 32'sd1, -32'sd1, 32'sd2, -32'sd2, 32'sd3, 1'b0));
        send_item(make_item(62, GRAD_MIN, GRAD_MAX, GRAD_MIN, GRAD_MAX, GRAD_MIN, 1'b0));
        send_item(make_item(-2, GRAD_MAX, GRAD_MAX, GRAD_MAX, GRAD_MAX, GRAD_MAX, 1'b0));
        send_item(make_item(-64, GRAD_MAX, GRAD_MAX, GRAD_MAX, GRAD_MAX, GRAD_MAX, 1'b0));
        send_item(make_item(5, rand_grad(), rand_grad(), rand_grad(), rand_grad(),
                            rand_grad(), 1'b1));
        wait_idle();

        // count below the minimum acts as two; bad index ends the row
        write_count(7'd0);
        send_item(make_item(-1, 32'sd100, 32'sd7, 32'sd7, 32'sd7, -32'sd100, 1'b0));
        send_item(make_item(0, 32'sd5, 32'sd6, 32'sd7, 32'sd8, 32'sd9, 1'b0));
        send_item(make_item(1, -32'sd5, 32'sd6, 32'sd7, 32'sd8, -32'sd9, 1'b0));
        send_item(make_item(2, GRAD_MAX, GRAD_MAX, GRAD_MAX, GRAD_MAX, GRAD_MAX, 1'b1));
        wait_idle();

        // count above the maximum, then shrunk twice inside one row
        write_count(7'd65);
        send_item(make_item(63, 32'sd11, 32'sd12, 32'sd13, 32'sd14, 32'sd15, 1'b0));
        wait_idle();
        write_count(7'd10);
        send_item(make_item(9, 32'sd21, 32'sd22, 32'sd23, 32'sd24, 32'sd25, 1'b0));
        send_item(make_item(4, 32'sd31, 32'sd32, 32'sd33, 32'sd34, 32'sd35, 1'b0));
        wait_idle();
        write_count(7'd5);
        send_item(make_item(4, 32'sd41, 32'sd42, 32'sd43, 32'sd44, 32'sd45, 1'b0));
        send_item(make_item(2, rand_grad(), rand_grad(), rand_grad(), rand_grad(),
                            rand_grad(), 1'b1));
        wait_idle();
        write_count(7'd1);
        send_item(make_item(0, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 1'b1));
        wait_idle();

        // pile extremes on point 0 high and point 1 low, then step back;
        // the drain over all points also shows the dropped sums were cleared
        write_count(7'd64);
        for (int i = 0; i < EXTREME_PAIRS; i++) begin
            send_item(make_item(0, GRAD_MAX, GRAD_MAX, GRAD_MAX, GRAD_MAX, GRAD_MAX,
                                1'b0));
            send_item(make_item(1, GRAD_MIN, GRAD_MIN, GRAD_MIN, GRAD_MIN, GRAD_MIN,
                                1'b0));
        end
        send_item(make_item(0, -32'sd5, -32'sd5, -32'sd5, -32'sd5, -32'sd5, 1'b0));
        send_item(make_item(1, 32'sd5, 32'sd5, 32'sd5, 32'sd5, 32'sd5, 1'b1));
        wait_idle();

        // random rows under each idle pattern
        run_phase(0, 0, 7'd127);
        run_phase(63, 0, 7'd2);
        run_phase(0, 63, CFG_W'($urandom_range(63, 3)));
        run_phase(24, 24, 7'd64);

        if (mismatches == 0 && results_due == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sgsa_pkg.sv
hw/rtl/sgsa_ram.sv
hw/rtl/sgsa_store.sv
hw/rtl/spline_gradient_scatter_add.sv
dv/spline_gradient_scatter_add_checker.sv
dv/spline_gradient_scatter_add_tb.sv
